// ===== rtl/nota_preamble_encoder_macros.svh =====
// assertion macros for the preamble encoder checker
// expects signals named clock and reset in the using module
`ifndef NOTA_PREAMBLE_ENCODER_MACROS_SVH
`define NOTA_PREAMBLE_ENCODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NPE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("npe check failed");

// antecedent implies consequent in the next cycle
`define NPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("npe check failed");

`endif

// ===== rtl/npe_pkg.sv =====
// shared types and constants of the preamble encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package npe_pkg;

   localparam int GroupBits = 7;
   localparam int MaxGroups = 9;
   localparam int BodyBits  = GroupBits * MaxGroups;
   localparam int GroupCntW = $clog2(MaxGroups + 1);

   localparam logic [2:0] OP_INT    = 3'd0;
   localparam logic [2:0] OP_BLOB   = 3'd1;
   localparam logic [2:0] OP_ARRAY  = 3'd2;
   localparam logic [2:0] OP_RECORD = 3'd3;
   localparam logic [2:0] OP_SYM    = 3'd4;

   localparam logic [7:0] TAG_BLOB   = 8'h00;
   localparam logic [7:0] TAG_ARRAY  = 8'h20;
   localparam logic [7:0] TAG_RECORD = 8'h30;
   localparam logic [7:0] TAG_INT    = 8'h60;
   localparam logic [7:0] TAG_SYM    = 8'h70;
   localparam logic [7:0] INT_SIGN   = 8'h08;

   typedef struct packed {
      logic load;
      logic scan;
      logic emit_head;
      logic emit_body;
   } ctrl_type;

   typedef struct packed {
      logic can_drop;
      logic g_zero;
      logic g_one;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/npe_digit_sr.sv =====
// digit-serial datapath: 7-bit group shift register, head field, group counter
// depends on npe_pkg
`timescale 1ns / 1ps
`default_nettype none

module npe_digit_sr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [2:0]          req_opcode,
   input  wire logic signed [63:0]  req_value,
   input  wire logic [3:0]          req_symbol_code,
   input  wire npe_pkg::ctrl_type   ctrl,
   output npe_pkg::status_type      status,
   output logic [7:0]               out_byte,
   output logic                     out_last
);

   logic [npe_pkg::BodyBits-1:0]  body_ff, body_in;
   logic [3:0]                    hfield_ff, hfield_in;
   logic [npe_pkg::GroupCntW-1:0] g_ff, g_in;
   logic [7:0]                    tag_ff, tag_in;
   logic                          low4_ff, low4_in;

   logic [63:0]                   mag;
   logic [npe_pkg::GroupBits-1:0] top_group;

   assign top_group = body_ff[npe_pkg::BodyBits-1 -: npe_pkg::GroupBits];

   always_comb begin
      mag = req_value;
      if (req_opcode == npe_pkg::OP_INT && req_value[63]) begin
         if (req_value[62:0] == 63'd0) begin
            mag = {1'b0, {63{1'b1}}};
         end else begin
            mag = 64'd0 - req_value;
         end
      end
   end

   always_comb begin
      status.g_zero   = (g_ff == '0);
      status.g_one    = (g_ff == npe_pkg::GroupCntW'(1));
      status.can_drop = !status.g_zero && (hfield_ff == 4'd0) &&
                        (top_group[6:4] == 3'd0) && (low4_ff || !top_group[3]);
   end

   always_comb begin
      body_in   = body_ff;
      hfield_in = hfield_ff;
      g_in      = g_ff;
      tag_in    = tag_ff;
      low4_in   = low4_ff;
      if (ctrl.load) begin
         body_in   = mag[npe_pkg::BodyBits-1:0];
         hfield_in = {3'b000, mag[63]};
         g_in      = npe_pkg::GroupCntW'(npe_pkg::MaxGroups);
         low4_in   = 1'b1;
         case (req_opcode)
            npe_pkg::OP_INT: begin
               tag_in  = req_value[63] ? (npe_pkg::TAG_INT | npe_pkg::INT_SIGN)
                                       : npe_pkg::TAG_INT;
               low4_in = 1'b0;
            end
            npe_pkg::OP_BLOB:   tag_in = npe_pkg::TAG_BLOB;
            npe_pkg::OP_ARRAY:  tag_in = npe_pkg::TAG_ARRAY;
            npe_pkg::OP_RECORD: tag_in = npe_pkg::TAG_RECORD;
            default: begin
               tag_in    = npe_pkg::TAG_SYM | {4'h0, req_symbol_code};
               hfield_in = 4'd0;
               g_in      = '0;
            end
         endcase
      end else if (ctrl.scan) begin
         body_in   = {body_ff[npe_pkg::BodyBits-npe_pkg::GroupBits-1:0],
                      {npe_pkg::GroupBits{1'b0}}};
         hfield_in = top_group[3:0];
         g_in      = g_ff - npe_pkg::GroupCntW'(1);
      end else if (ctrl.emit_body) begin
         body_in   = {body_ff[npe_pkg::BodyBits-npe_pkg::GroupBits-1:0],
                      {npe_pkg::GroupBits{1'b0}}};
         g_in      = g_ff - npe_pkg::GroupCntW'(1);
      end
   end

   always_comb begin
      if (ctrl.emit_head) begin
         out_byte = {!status.g_zero, tag_ff[6:0] | {3'b000, hfield_ff}};
         out_last = status.g_zero;
      end else begin
         out_byte = {!status.g_one, top_group};
         out_last = status.g_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff <= '0;
      end else begin
         g_ff <= g_in;
      end
      body_ff   <= body_in;
      hfield_ff <= hfield_in;
      tag_ff    <= tag_in;
      low4_ff   <= low4_in;
   end

endmodule

`default_nettype wire

// ===== rtl/npe_fsm.sv =====
// sequencer: load, leading-group scan, head byte, group bytes
// depends on npe_pkg
`timescale 1ns / 1ps
`default_nettype none

module npe_fsm (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                opcode_ok,
   input  wire npe_pkg::status_type status,
   output logic                     busy,
   output npe_pkg::ctrl_type        ctrl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HEAD = 2'd2;
   localparam logic [1:0] ST_BODY = 2'd3;

   logic [1:0] state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && opcode_ok) begin
               ctrl.load = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.can_drop) begin
               ctrl.scan = 1'b1;
            end else begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            ctrl.emit_head = 1'b1;
            state_in       = status.g_zero ? ST_IDLE : ST_BODY;
         end
         ST_BODY: begin
            ctrl.emit_body = 1'b1;
            if (status.g_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nota_preamble_encoder.sv =====
// top level of the preamble encoder: sequencer, digit datapath, output register
// depends on npe_pkg, npe_fsm, npe_digit_sr
//
//   channel   ports                                         handshake
//   request   req_opcode req_value req_symbol_code          start && !busy
//   response  rsp_out_byte rsp_last                         rsp_strobe, one cycle
//
// a number item runs a leading-group scan of the 63-bit shift register (one group
// per cycle while a group can be dropped, then a decide step), then emits one
// byte per cycle; a symbol emits only its head byte, an unused opcode is taken and dropped
// bytes leave the output register one per cycle, the last one as busy falls
// synchronous reset clears the sequencer and the strobe; no stall on the output
`timescale 1ns / 1ps
`default_nettype none

module nota_preamble_encoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_opcode,
   input  wire logic signed [63:0] req_value,
   input  wire logic [3:0]         req_symbol_code,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last
);

   npe_pkg::ctrl_type   ctrl;
   npe_pkg::status_type status;
   logic                opcode_ok;
   logic [7:0]          dp_byte;
   logic                dp_last;
   logic                emit;

   logic                strobe_ff, strobe_in;
   logic                last_ff, last_in;
   logic [7:0]          byte_ff, byte_in;

   assign opcode_ok = req_opcode inside {[npe_pkg::OP_INT:npe_pkg::OP_SYM]};

   npe_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode_ok (opcode_ok),
      .status    (status),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   npe_digit_sr u_sr (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_symbol_code (req_symbol_code),
      .ctrl            (ctrl),
      .status          (status),
      .out_byte        (dp_byte),
      .out_last        (dp_last)
   );

   assign emit      = ctrl.emit_head || ctrl.emit_body;
   assign strobe_in = emit;
   assign last_in   = emit && dp_last;
   assign byte_in   = dp_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
      byte_ff <= byte_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_last     = last_ff;
   assign rsp_out_byte = byte_ff;

endmodule

`default_nettype wire

// ===== rtl/npe_checker.sv =====
// port-level checker for the preamble encoder, bound to the top level
// depends on npe_pkg and nota_preamble_encoder_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "nota_preamble_encoder_macros.svh"

module npe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [2:0] req_opcode,
   input wire logic       rsp_strobe,
   input wire logic       rsp_last
);

   logic take;

   assign take = start && !busy &&
                 (req_opcode inside {[npe_pkg::OP_INT:npe_pkg::OP_SYM]});

   `NPE_ASSERT_NEXT(a_take_busy, take, busy)
   `NPE_ASSERT_NOW(a_last_strobe, rsp_last, rsp_strobe)
   `NPE_ASSERT_NEXT(a_word_run, rsp_strobe && !rsp_last, rsp_strobe)
   `NPE_ASSERT_NEXT(a_gap_after_last, rsp_strobe && rsp_last, !rsp_strobe)
   `NPE_ASSERT_NEXT(a_idle_quiet, !busy && !rsp_strobe, !rsp_strobe)

endmodule

bind nota_preamble_encoder npe_checker u_npe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_strobe (rsp_strobe),
   .rsp_last   (rsp_last)
);

`default_nettype wire

// ===== sim/tb_nota_preamble_encoder.sv =====
// self-checking testbench of nota_preamble_encoder: directed table, then random words
// depends on npe_pkg and the encoder rtl; predicts the header bytes of PREDICTED rows and random words on its own
`timescale 1ns / 1ps

module tb_nota_preamble_encoder;

   localparam logic [7:0]  CONT_FLAG      = 8'h80;
   localparam logic [63:0] GROUP_MASK     = 64'h7f;
   localparam int unsigned INT_LOW_BITS   = 3;
   localparam int unsigned COUNT_LOW_BITS = 4;
   localparam logic [63:0] MIN_INT        = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_INT        = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES       = 64'hffff_ffff_ffff_ffff;
   localparam int          RANDOM_ITEMS   = 300;
   localparam int          QUIET_LIMIT    = 2000;
   localparam int          DRAIN_CYCLES   = 24;
   localparam int          PREDICTED      = -1;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
   } enc_byte_type;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] val;
      logic [3:0]  sym;
      int          n_known;
      logic [79:0] known_bytes;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_opcode;
   logic signed [63:0] req_value;
   logic [3:0]         req_symbol_code;
   logic               rsp_strobe;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last;

   enc_byte_type expected_bytes[$];
   enc_byte_type head_word;
   stim_row_type stim_rows[$];
   int        fail_count = 0;
   int        quiet_cycles = 0;
   int        random_done;
   bit        gaps_on;
   logic [2:0]  rnd_op;
   logic [63:0] rnd_val;

   nota_preamble_encoder u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_symbol_code (req_symbol_code),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // header bytes of one item, head byte first
   function automatic void encode_preamble(input logic [2:0] op, input logic [63:0] val,
                                           input logic [3:0] sym);
      logic [7:0]  head;
      logic [7:0]  low_mask;
      logic [63:0] mag;
      logic [63:0] part;
      int unsigned low_bits;
      int unsigned len;
      int unsigned groups;
      int unsigned shift;
      enc_byte_type w;
      mag = val;
      low_bits = COUNT_LOW_BITS;
      len = 0;
      case (op)
         npe_pkg::OP_INT: begin
            head = npe_pkg::TAG_INT;
            low_bits = INT_LOW_BITS;
            if (val[63]) begin
               head = head | npe_pkg::INT_SIGN;
               mag = (val == MIN_INT) ? MAX_INT : -val;
            end
         end
         npe_pkg::OP_BLOB: head = npe_pkg::TAG_BLOB;
         npe_pkg::OP_ARRAY: head = npe_pkg::TAG_ARRAY;
         npe_pkg::OP_RECORD: head = npe_pkg::TAG_RECORD;
         npe_pkg::OP_SYM: begin
            w.out_byte = npe_pkg::TAG_SYM | {4'd0, sym};
            w.last = 1'b1;
            expected_bytes.push_back(w);
            return;
         end
         default: return;
      endcase
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) len = i + 1;
      end
      groups = (len > low_bits) ? (len - low_bits + 6) / 7 : 0;
      shift = groups * 7;
      low_mask = (8'd1 << low_bits) - 8'd1;
      part = mag >> shift;
      head = head | (part[7:0] & low_mask);
      if (groups != 0) head = head | CONT_FLAG;
      w.out_byte = head;
      w.last = (groups == 0);
      expected_bytes.push_back(w);
      for (int g = 0; g < groups; g++) begin
         shift = shift - 7;
         part = (mag >> shift) & GROUP_MASK;
         w.out_byte = part[7:0];
         if (shift != 0) w.out_byte = w.out_byte | CONT_FLAG;
         w.last = (shift == 0);
         expected_bytes.push_back(w);
      end
   endfunction

   // known bytes are left-justified, first byte in the top eight bits
   function automatic void add_row(input logic [2:0] op, input logic [63:0] val,
                                   input logic [3:0] sym, input int n_known,
                                   input logic [79:0] known_bytes);
      stim_row_type row;
      row.op = op;
      row.val = val;
      row.sym = sym;
      row.n_known = n_known;
      row.known_bytes = known_bytes;
      stim_rows.push_back(row);
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [2:0] op, input logic [63:0] val,
                            input logic [3:0] sym, input int n_known,
                            input logic [79:0] known_bytes);
      enc_byte_type w;
      while (gaps_on && $urandom_range(0, 99) < 36) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      req_symbol_code <= sym;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (n_known == PREDICTED) begin
         encode_preamble(op, val, sym);
      end else begin
         for (int k = 0; k < n_known; k++) begin
            w.out_byte = known_bytes[79 - 8 * k -: 8];
            w.last = (k == n_known - 1);
            expected_bytes.push_back(w);
         end
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: no word expected, actual %h", rsp_out_byte);
            fail_count++;
         end else begin
            head_word = expected_bytes.pop_front();
            if (rsp_out_byte !== head_word.out_byte) begin
               $error("out_byte: expected %h, actual %h", head_word.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last !== head_word.last) begin
               $error("last: expected %b, actual %b", head_word.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_value = '0;
      req_symbol_code = '0;
      gaps_on = 1'b1;

      add_row(npe_pkg::OP_INT, 64'd0, 4'd15, 1, {8'h60, 72'd0});
      add_row(npe_pkg::OP_INT, 64'd7, 4'd0, 1, {8'h67, 72'd0});
      add_row(npe_pkg::OP_INT, ALL_ONES, 4'd0, 1, {8'h69, 72'd0});
      add_row(npe_pkg::OP_INT, 64'd8, 4'd0, 2, {16'he008, 64'd0});
      add_row(npe_pkg::OP_INT, MAX_INT, 4'd0, 10, {8'he0, {8{8'hff}}, 8'h7f});
      add_row(npe_pkg::OP_INT, MIN_INT, 4'd0, 10, {8'he8, {8{8'hff}}, 8'h7f});
      add_row(npe_pkg::OP_INT, MIN_INT + 64'd1, 4'd0, 10, {8'he8, {8{8'hff}}, 8'h7f});
      add_row(npe_pkg::OP_BLOB, 64'd0, 4'd0, 1, {8'h00, 72'd0});
      add_row(npe_pkg::OP_BLOB, ALL_ONES, 4'd0, 10, {8'h81, {8{8'hff}}, 8'h7f});
      add_row(npe_pkg::OP_BLOB, MIN_INT, 4'd0, 10, {8'h81, {8{8'h80}}, 8'h00});
      add_row(npe_pkg::OP_ARRAY, 64'd15, 4'd0, 1, {8'h2f, 72'd0});
      add_row(npe_pkg::OP_RECORD, 64'd16, 4'd0, 2, {16'hb010, 64'd0});
      add_row(npe_pkg::OP_SYM, 64'd0, 4'd0, 1, {8'h70, 72'd0});
      add_row(npe_pkg::OP_SYM, ALL_ONES, 4'd15, 1, {8'h7f, 72'd0});
      add_row(npe_pkg::OP_SYM, 64'd1234, 4'd5, 1, {8'h75, 72'd0});
      add_row(3'd5, ALL_ONES, 4'd15, 0, '0);
      add_row(3'd6, 64'd1, 4'd0, 0, '0);
      add_row(3'd7, MIN_INT, 4'd9, 0, '0);
      add_row(npe_pkg::OP_INT, 64'd1000, 4'd3, PREDICTED, '0);
      add_row(npe_pkg::OP_INT, -64'd1000, 4'd0, PREDICTED, '0);
      add_row(npe_pkg::OP_INT, 64'h0000_0001_0000_0000, 4'd0, PREDICTED, '0);
      add_row(npe_pkg::OP_ARRAY, 64'h0000_0000_dead_beef, 4'd0, PREDICTED, '0);
      add_row(npe_pkg::OP_RECORD, 64'h0123_4567_89ab_cdef, 4'd0, PREDICTED, '0);
      add_row(npe_pkg::OP_BLOB, 64'd127, 4'd0, PREDICTED, '0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         send_word(stim_rows[r].op, stim_rows[r].val, stim_rows[r].sym,
                   stim_rows[r].n_known, stim_rows[r].known_bytes);
      end

      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         gaps_on = !(random_done >= 120 && random_done < 200);
         if ($urandom_range(0, 99) < 8) rnd_op = 3'($urandom_range(5, 7));
         else rnd_op = 3'($urandom_range(0, 4));
         rnd_val = {$urandom, $urandom};
         case ($urandom_range(0, 11))
            0: rnd_val = MIN_INT;
            1: rnd_val = MAX_INT;
            2: rnd_val = 64'd0;
            default: rnd_val = rnd_val >> $urandom_range(0, 63);
         endcase
         if ($urandom_range(0, 99) < ((rnd_op == npe_pkg::OP_INT) ? 50 : 10)) begin
            rnd_val = -rnd_val;
         end
         send_word(rnd_op, rnd_val, 4'($urandom_range(0, 15)), PREDICTED, '0);
         if (rnd_op <= npe_pkg::OP_SYM) random_done++;
      end
      start <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
